@@ design/wgc_pkg.sv @@
// shared constants, tables and helper functions for the waypoint go-to-goal controller
// no dependencies
`timescale 1ns / 1ps

package wgc_pkg;

    localparam int MAX_POINTS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // datapath widths of the shared cordic
    localparam int XW = 26;
    localparam int ZW = 22;

    localparam logic signed [ZW-1:0] ANG_PI      = 22'sd205887;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 22'sd102944;
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = 22'sd411775;
    localparam logic [15:0]          INV_GAIN    = 16'd39797;

    localparam logic [1:0] STATUS_TURN  = 2'd0;
    localparam logic [1:0] STATUS_DRIVE = 2'd1;
    localparam logic [1:0] STATUS_REACH = 2'd2;
    localparam logic [1:0] STATUS_DONE  = 2'd3;

    localparam logic [2:0] REG_ANGLE_GAIN = 3'd0;
    localparam logic [2:0] REG_DIST_GAIN  = 3'd1;
    localparam logic [2:0] REG_ANGLE_TOL  = 3'd2;
    localparam logic [2:0] REG_DIST_TOL   = 3'd3;
    localparam logic [2:0] REG_POINTS     = 3'd4;

    typedef struct packed {
        logic                 start;
        logic                 vectoring;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_req_t;

    function automatic logic [15:0] wgc_atan(input logic [4:0] i);
        logic [15:0] r;
        unique case (i)
            5'd0:    r = 16'd51472;
            5'd1:    r = 16'd30386;
            5'd2:    r = 16'd16055;
            5'd3:    r = 16'd8150;
            5'd4:    r = 16'd4091;
            5'd5:    r = 16'd2047;
            5'd6:    r = 16'd1024;
            5'd7:    r = 16'd512;
            5'd8:    r = 16'd256;
            5'd9:    r = 16'd128;
            5'd10:   r = 16'd64;
            5'd11:   r = 16'd32;
            5'd12:   r = 16'd16;
            5'd13:   r = 16'd8;
            5'd14:   r = 16'd4;
            5'd15:   r = 16'd2;
            5'd16:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] wgc_init_x(input logic [4:0] idx);
        logic [15:0] r;
        unique case (idx)
            5'd0, 5'd3:                      r = 16'd4096;
            5'd1, 5'd2, 5'd4:                r = 16'd12288;
            5'd5, 5'd6, 5'd9:                r = 16'd20480;
            5'd7, 5'd8, 5'd11, 5'd12, 5'd15: r = 16'd28672;
            5'd10, 5'd13, 5'd14:             r = 16'd36864;
            default:                         r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] wgc_init_y(input logic [4:0] idx);
        logic [15:0] r;
        unique case (idx)
            5'd0, 5'd1, 5'd6, 5'd7, 5'd10, 5'd11: r = 16'd32768;
            5'd2, 5'd3:                           r = 16'd20480;
            5'd4, 5'd5, 5'd8, 5'd9:               r = 16'd12288;
            5'd12, 5'd13:                         r = 16'd24576;
            5'd14, 5'd15:                         r = 16'd16384;
            default:                              r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] wgc_sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

@@ design/wgc_cordic.sv @@
// shared iterative cordic: vectoring (angle and length) or rotating (cosine)
// one micro-rotation per cycle; depends on wgc_pkg
`timescale 1ns / 1ps

module wgc_cordic import wgc_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cordic_req_t          req,
    output logic                 done,
    output logic signed [XW-1:0] x_out,
    output logic signed [ZW-1:0] z_out
);

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [4:0]           iter_reg;
    logic                 run_reg, done_reg, vec_reg;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 up;

    always_comb begin
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        at = ZW'($signed({1'b0, wgc_atan(iter_reg)}));
        up = vec_reg ? (y_reg > 0) : (z_reg < 0);
        if (vec_reg ? up : !up) begin
            x_next = vec_reg ? x_reg + ys : x_reg - ys;
            y_next = vec_reg ? y_reg - xs : y_reg + xs;
            z_next = vec_reg ? z_reg + at : z_reg - at;
        end else begin
            x_next = vec_reg ? x_reg - ys : x_reg + ys;
            y_next = vec_reg ? y_reg + xs : y_reg - xs;
            z_next = vec_reg ? z_reg - at : z_reg + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg  <= 1'b1;
                iter_reg <= '0;
            end else if (run_reg) begin
                iter_reg <= iter_reg + 5'd1;
                if (iter_reg == 5'(NSTEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            z_reg   <= req.z;
            vec_reg <= req.vectoring;
        end else if (run_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

@@ design/waypoint_go_to_goal_controller.sv @@
// top level of the waypoint go-to-goal controller: waypoint memory, sequencer,
// multipliers and register port; depends on wgc_pkg and wgc_cordic
`timescale 1ns / 1ps

// Usage
// The s_ channel takes one transaction at a time. A load (s_action 0) writes
// s_load_x / s_load_y into slot s_load_index and gives no result.
// A control tick (s_action 1) carries the pose and gives one m_ transaction.
// A tick runs: a memory read, a vectoring pass of the shared cordic (skipped
// when the pose sits on the waypoint), the distance and heading error states,
// then either a turn state, or a rotating cordic pass for the cosine plus the
// multiply and round states for a drive. Reached ticks stop after the error
// states; done ticks go straight from the memory read to the output.
// s_ready is low while a tick is in work. The result sits in an output
// register; if the receiver stalls, the sequencer holds the next result until
// that register is free. Reset restores registers and the built-in waypoints
// (per-slot valid bits clear at once, no sweep) and targets waypoint zero.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12 and 16.

module waypoint_go_to_goal_controller import wgc_pkg::*; #(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [3:0]         s_load_index,
    input  logic [15:0]        s_load_x,
    input  logic [15:0]        s_load_y,
    input  logic [15:0]        s_pose_x,
    input  logic [15:0]        s_pose_y,
    input  logic signed [14:0] s_pose_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [15:0] m_linear_cmd,
    output logic signed [15:0] m_angular_cmd,
    output logic [4:0]         m_target_number
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FETCH = 4'd1;
    localparam logic [3:0] ST_VEC   = 4'd2;
    localparam logic [3:0] ST_DIST  = 4'd3;
    localparam logic [3:0] ST_ERR   = 4'd4;
    localparam logic [3:0] ST_TEST  = 4'd5;
    localparam logic [3:0] ST_TURN  = 4'd6;
    localparam logic [3:0] ST_COS   = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_ROUND = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    // configuration
    logic [15:0] angle_gain_reg, distance_gain_reg;
    logic [11:0] angle_tol_reg, dist_tol_reg;
    logic [4:0]  points_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_gain_reg    <= 16'd2560;
            distance_gain_reg <= 16'd512;
            angle_tol_reg     <= 12'd41;
            dist_tol_reg      <= 12'd410;
            points_reg        <= 5'd16;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_ANGLE_GAIN: angle_gain_reg    <= pwdata[15:0];
                REG_DIST_GAIN:  distance_gain_reg <= pwdata[15:0];
                REG_ANGLE_TOL:  angle_tol_reg     <= pwdata[11:0];
                REG_DIST_TOL:   dist_tol_reg      <= pwdata[11:0];
                REG_POINTS:     points_reg        <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ANGLE_GAIN: prdata = 32'(angle_gain_reg);
            REG_DIST_GAIN:  prdata = 32'(distance_gain_reg);
            REG_ANGLE_TOL:  prdata = 32'(angle_tol_reg);
            REG_DIST_TOL:   prdata = 32'(dist_tol_reg);
            REG_POINTS:     prdata = 32'(points_reg);
            default:        prdata = '0;
        endcase
    end

    // sequencer state and datapath registers
    logic [3:0]  state_reg, state_next;
    logic [4:0]  target_reg;
    logic [15:0] pose_x_reg, pose_y_reg;
    logic signed [14:0] head_reg;

    logic s_fire, ld_ok;
    logic [AW-1:0] ld_addr;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign ld_addr = AW'(s_load_index);
    assign ld_ok   = 32'(s_load_index) < 32'(MAX_POINTS);

    // waypoint memory; a slot never loaded reads as its built-in point
    logic [15:0]           mem_x [MAX_POINTS];
    logic [15:0]           mem_y [MAX_POINTS];
    logic [MAX_POINTS-1:0] wp_valid_reg;
    logic [15:0]           rd_x_reg, rd_y_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (s_fire && !s_action && ld_ok) begin
            mem_x[ld_addr] <= s_load_x;
            mem_y[ld_addr] <= s_load_y;
        end
        rd_x_reg <= mem_x[AW'(target_reg)];
        rd_y_reg <= mem_y[AW'(target_reg)];
        rd_valid_reg <= wp_valid_reg[AW'(target_reg)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_valid_reg <= '0;
        end else if (s_fire && !s_action && ld_ok) begin
            wp_valid_reg[ld_addr] <= 1'b1;
        end
    end

    // shared cordic
    cordic_req_t          creq;
    logic                 cdone;
    logic signed [XW-1:0] cx;
    logic signed [ZW-1:0] cz;

    wgc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .done    (cdone),
        .x_out   (cx),
        .z_out   (cz)
    );

    logic signed [ZW-1:0] ang_reg, err_reg;
    logic signed [XW-1:0] mag_reg;
    logic signed [42:0]   mag_prod_reg;
    logic [17:0]          dist_reg;
    logic signed [38:0]   turn_prod_reg;
    logic signed [17:0]   cos_reg;
    logic [33:0]          p1_reg;
    logic signed [52:0]   p2_reg;
    logic                 cos_neg_reg;
    logic [1:0]           res_status_reg;
    logic signed [15:0]   res_lin_reg, res_ang_reg;

    // fetch-stage vector
    logic [15:0]          wp_x, wp_y;
    logic signed [17:0]   dx, dy;
    logic signed [XW-1:0] vx, vy;
    logic                 all_done;

    always_comb begin
        wp_x = rd_valid_reg ? rd_x_reg : wgc_init_x(target_reg);
        wp_y = rd_valid_reg ? rd_y_reg : wgc_init_y(target_reg);
        dx   = $signed({2'b00, wp_x}) - $signed({2'b00, pose_x_reg});
        dy   = $signed({2'b00, wp_y}) - $signed({2'b00, pose_y_reg});
        vx   = XW'(dx) <<< 4;
        vy   = XW'(dy) <<< 4;
        all_done = (target_reg >= points_reg) || (32'(target_reg) >= 32'(MAX_POINTS));
    end

    // heading error with a single wrap by two pi
    logic signed [ZW-1:0] err_raw, err_wrap, err_abs;
    logic signed [26:0]   d16;
    logic [17:0]          d12;

    always_comb begin
        err_raw = ang_reg - (ZW'(head_reg) <<< 4);
        if (err_raw > ANG_PI) begin
            err_wrap = err_raw - ANG_TWO_PI;
        end else if (err_raw < -ANG_PI) begin
            err_wrap = err_raw + ANG_TWO_PI;
        end else begin
            err_wrap = err_raw;
        end
        err_abs = (err_reg < 0) ? -err_reg : err_reg;
        d16 = 27'((mag_prod_reg + 43'sd32768) >>> 16);
        d12 = 18'((d16 + 27'sd8) >>> 4);
    end

    // cordic requests
    always_comb begin
        creq.start     = 1'b0;
        creq.vectoring = 1'b1;
        creq.x         = vx;
        creq.y         = vy;
        creq.z         = '0;
        if (state_reg == ST_FETCH && !all_done && !(dx == 0 && dy == 0)) begin
            creq.start = 1'b1;
            if (vx < 0) begin
                if (vy >= 0) begin
                    creq.x = vy;
                    creq.y = -vx;
                    creq.z = ANG_HALF_PI;
                end else begin
                    creq.x = -vy;
                    creq.y = vx;
                    creq.z = -ANG_HALF_PI;
                end
            end
        end else if (state_reg == ST_TEST && !(err_abs > ZW'({angle_tol_reg, 4'b0}))
                     && 32'(dist_reg) > 32'(dist_tol_reg)) begin
            creq.start     = 1'b1;
            creq.vectoring = 1'b0;
            creq.x         = XW'($signed({1'b0, INV_GAIN}));
            creq.y         = '0;
            if (err_reg > ANG_HALF_PI) begin
                creq.z = err_reg - ANG_PI;
            end else if (err_reg < -ANG_HALF_PI) begin
                creq.z = err_reg + ANG_PI;
            end else begin
                creq.z = err_reg;
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire && s_action) state_next = ST_FETCH;
            ST_FETCH: begin
                if (all_done) begin
                    state_next = ST_OUT;
                end else if (creq.start) begin
                    state_next = ST_VEC;
                end else begin
                    state_next = ST_DIST;
                end
            end
            ST_VEC:   if (cdone) state_next = ST_DIST;
            ST_DIST:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_TEST;
            ST_TEST: begin
                if (err_abs > ZW'({angle_tol_reg, 4'b0})) begin
                    state_next = ST_TURN;
                end else if (creq.start) begin
                    state_next = ST_COS;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_TURN:  state_next = ST_OUT;
            ST_COS:   if (cdone) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_OUT;
            ST_OUT:   if (!m_valid || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic signed [XW-1:0] cos_clamp;

    always_comb begin
        if (cx > XW'(65536)) begin
            cos_clamp = XW'(65536);
        end else if (cx < -XW'(65536)) begin
            cos_clamp = -XW'(65536);
        end else begin
            cos_clamp = cx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            target_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_TEST && state_next == ST_OUT) begin
                target_reg <= target_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pose_x_reg <= s_pose_x;
            pose_y_reg <= s_pose_y;
            head_reg   <= s_pose_heading;
        end
        unique case (state_reg)
            ST_FETCH: begin
                res_status_reg <= STATUS_DONE;
                res_lin_reg    <= '0;
                res_ang_reg    <= '0;
                ang_reg        <= '0;
                mag_reg        <= '0;
            end
            ST_VEC: begin
                ang_reg <= cz;
                mag_reg <= cx;
            end
            ST_DIST: begin
                mag_prod_reg <= 43'(mag_reg) * $signed({27'd0, INV_GAIN});
                err_reg      <= err_wrap;
            end
            ST_ERR: dist_reg <= d12;
            ST_TEST: begin
                turn_prod_reg  <= $signed({23'd0, angle_gain_reg}) * 39'(err_reg);
                p1_reg         <= 34'(distance_gain_reg) * 34'(dist_reg);
                cos_neg_reg    <= (err_reg > ANG_HALF_PI) || (err_reg < -ANG_HALF_PI);
                res_status_reg <= STATUS_REACH;
            end
            ST_TURN: begin
                res_status_reg <= STATUS_TURN;
                res_ang_reg    <= wgc_sat16(64'((turn_prod_reg + 39'sd32768) >>> 16));
            end
            ST_COS: begin
                cos_reg <= cos_neg_reg ? -18'(cos_clamp) : 18'(cos_clamp);
            end
            ST_MUL: p2_reg <= $signed({19'd0, p1_reg}) * 53'(cos_reg);
            ST_ROUND: begin
                res_status_reg <= STATUS_DRIVE;
                res_lin_reg    <= wgc_sat16(64'((p2_reg + 53'sd134217728) >>> 28));
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
            m_status        <= res_status_reg;
            m_linear_cmd    <= res_lin_reg;
            m_angular_cmd   <= res_ang_reg;
            m_target_number <= target_reg;
        end
    end

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the waypoint go-to-goal controller
// holds its own cordic-based predictor; depends on wgc_pkg and the controller rtl
`timescale 1ns / 1ps

module testbench;
    import wgc_pkg::*;

    typedef struct packed {
        logic        action;
        logic [3:0]  load_index;
        logic [15:0] load_x;
        logic [15:0] load_y;
        logic [15:0] pose_x;
        logic [15:0] pose_y;
        logic [14:0] pose_heading;
    } pose_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] linear_cmd;
        logic [15:0] angular_cmd;
        logic [4:0]  target_number;
    } command_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic [3:0] s_load_index = '0;
    logic [15:0] s_load_x = '0, s_load_y = '0, s_pose_x = '0, s_pose_y = '0;
    logic signed [14:0] s_pose_heading = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic signed [15:0] m_linear_cmd, m_angular_cmd;
    logic [4:0] m_target_number;

    waypoint_go_to_goal_controller uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [15:0] way_x [16];
    logic [15:0] way_y [16];
    int unsigned goal_idx;
    int unsigned turn_gain, speed_gain, heading_tol, reach_tol, route_len;

    pose_item_t pending_items[$];
    command_t   expected_cmds[$];
    int errors = 0;
    int ticks_seen = 0;
    int loads_sent = 0;

    longint atan_step[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                              128, 64, 32, 16, 8, 4, 2, 1};

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint cordic_cos(longint z);
        longint x = 39797, y = 0, nx, ny;
        bit flip = 0;
        if (z > 102944) begin z -= 205887; flip = 1; end
        else if (z < -102944) begin z += 205887; flip = 1; end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin nx = x - shr(y, i); ny = y + shr(x, i); z -= atan_step[i]; end
            else begin nx = x + shr(y, i); ny = y - shr(x, i); z += atan_step[i]; end
            x = nx; y = ny;
        end
        if (x > 65536) x = 65536;
        if (x < -65536) x = -65536;
        return flip ? -x : x;
    endfunction

    task automatic steer(input pose_item_t it);
        longint x, y, z, t, nx, ny, span, head, err, lin, turn;
        int unsigned lim;
        command_t c;
        if (!it.action) begin
            way_x[it.load_index] = it.load_x;
            way_y[it.load_index] = it.load_y;
            return;
        end
        lin = 0; turn = 0;
        lim = route_len > 16 ? 16 : route_len;
        if (goal_idx >= lim) begin
            c.status = STATUS_DONE;
        end else begin
            x = (longint'(way_x[goal_idx]) - longint'(it.pose_x)) * 16;
            y = (longint'(way_y[goal_idx]) - longint'(it.pose_y)) * 16;
            z = 0;
            if (x == 0 && y == 0) begin
                z = 0;
            end else begin
                if (x < 0) begin
                    t = x;
                    if (y >= 0) begin x = y; y = -t; z = 102944; end
                    else begin x = -y; y = t; z = -102944; end
                end
                for (int i = 0; i < 16; i++) begin
                    if (y > 0) begin
                        nx = x + shr(y, i); ny = y - shr(x, i); z += atan_step[i];
                    end else begin
                        nx = x - shr(y, i); ny = y + shr(x, i); z -= atan_step[i];
                    end
                    x = nx; y = ny;
                end
            end
            span = (x * 39797 + 32768) >>> 16;
            span = (span + 8) >>> 4;
            head = longint'(signed'(it.pose_heading));
            err = z - head * 16;
            if (err > 205887) err -= 411775;
            else if (err < -205887) err += 411775;
            if ((err < 0 ? -err : err) > longint'(heading_tol) * 16) begin
                c.status = STATUS_TURN;
                turn = clip16(shr(longint'(turn_gain) * err + 32768, 16));
            end else if (span > longint'(reach_tol)) begin
                c.status = STATUS_DRIVE;
                lin = clip16(shr(longint'(speed_gain) * span * cordic_cos(err)
                                 + (longint'(1) << 27), 28));
            end else begin
                c.status = STATUS_REACH;
                goal_idx++;
            end
        end
        c.linear_cmd = lin[15:0];
        c.angular_cmd = turn[15:0];
        c.target_number = goal_idx[4:0];
        expected_cmds.push_back(c);
    endtask

    task automatic report(input string what, input command_t got, input command_t want);
        errors++;
        $display("mismatch %s: got %p expected %p", what, got, want);
    endtask

    // driver: bursts with gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                steer(pending_items.pop_front());
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             !(s_valid && s_ready && pending_items.size() == 0)) begin
                    s_valid <= 1'b1;
                    {s_action, s_load_index, s_load_x, s_load_y, s_pose_x, s_pose_y,
                     s_pose_heading} <= pending_items[0];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_mode = 0;
    always @(posedge aclk) begin
        command_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_status, m_linear_cmd, m_angular_cmd, m_target_number};
                ticks_seen++;
                if (expected_cmds.size() == 0) begin
                    errors++;
                    $display("unexpected result transaction %p", got);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.status != want.status) report("status", got, want);
                    if (got.linear_cmd != want.linear_cmd) report("linear_cmd", got, want);
                    if (got.angular_cmd != want.angular_cmd) report("angular_cmd", got, want);
                    if (got.target_number != want.target_number)
                        report("target_number", got, want);
                end
            end
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_ANGLE_GAIN: turn_gain = val[15:0];
            REG_DIST_GAIN:  speed_gain = val[15:0];
            REG_ANGLE_TOL:  heading_tol = val[11:0];
            REG_DIST_TOL:   reach_tol = val[11:0];
            default:        route_len = val[4:0];
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_cmds.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic pose_item_t tick(input logic [15:0] px, py, input logic [14:0] h);
        pose_item_t it;
        it = '0;
        it.action = 1'b1; it.pose_x = px; it.pose_y = py; it.pose_heading = h;
        it.load_index = 4'($urandom); it.load_x = 16'($urandom); it.load_y = 16'($urandom);
        return it;
    endfunction

    function automatic pose_item_t load(input logic [3:0] i, input logic [15:0] lx, ly);
        pose_item_t it;
        it = tick(16'($urandom), 16'($urandom), 15'($urandom));
        it.action = 1'b0; it.load_index = i; it.load_x = lx; it.load_y = ly;
        return it;
    endfunction

    // heading toward waypoint g from pose, with a small random offset
    function automatic logic [14:0] aim(input int g, input logic [15:0] px, py);
        real a;
        a = $atan2(real'(way_y[g]) - real'(py), real'(way_x[g]) - real'(px));
        return 15'($rtoi(a * 4096.0) + $urandom_range(0, 40) - 20);
    endfunction

    // predictor's view used only for shaping stimulus
    task automatic add_walk(input int n);
        logic [15:0] px, py;
        int g;
        for (int k = 0; k < n; k++) begin
            g = $urandom_range(0, 15);
            case ($urandom_range(0, 5))
                0: begin px = way_x[g]; py = way_y[g]; end
                1, 2: begin
                    px = way_x[g] + 16'($urandom_range(0, 800)) - 16'd400;
                    py = way_y[g] + 16'($urandom_range(0, 800)) - 16'd400;
                end
                default: begin px = 16'($urandom); py = 16'($urandom); end
            endcase
            if ($urandom_range(0, 19) == 0)
                pending_items.push_back(load(4'($urandom), 16'($urandom), 16'($urandom)));
            else if ($urandom_range(0, 2) == 0)
                pending_items.push_back(tick(px, py, 15'($urandom)));
            else
                pending_items.push_back(tick(px, py, aim(g, px, py)));
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            way_x[i] = wgc_init_x(5'(i));
            way_y[i] = wgc_init_y(5'(i));
        end
        goal_idx = 0;
        turn_gain = 2560; speed_gain = 512; heading_tol = 41; reach_tol = 410; route_len = 16;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: built-in route, exact hits, extremes, loads
        pending_items.push_back(tick(16'd4096, 16'd0, 15'd0));
        pending_items.push_back(tick(16'd4096, 16'd0, 15'd6434));
        pending_items.push_back(tick(16'd4096, 16'd32768, 15'd0));
        pending_items.push_back(tick(16'hffff, 16'hffff, 15'h3fff));
        pending_items.push_back(tick(16'd0, 16'd0, 15'h4000));
        pending_items.push_back(tick(16'hffff, 16'd0, 15'h4000));
        pending_items.push_back(tick(16'd12288, 16'd32768, 15'd0));
        pending_items.push_back(load(4'd15, 16'hffff, 16'hffff));
        pending_items.push_back(load(4'd2, 16'd0, 16'd0));
        pending_items.push_back(tick(16'd0, 16'd0, 15'd0));
        pending_items.push_back(tick(16'hffff, 16'hffff, 15'd0));
        pending_items.push_back(load(4'd3, 16'h8000, 16'h8000));
        pending_items.push_back(tick(16'h7000, 16'h7000, 15'd0));
        drain();

        // extreme gains and tolerances, short route to reach done
        apb_write(REG_ANGLE_GAIN, 32'hffff);
        apb_write(REG_DIST_GAIN, 32'hffff);
        apb_write(REG_ANGLE_TOL, 32'd0);
        apb_write(REG_DIST_TOL, 32'd0);
        apb_write(REG_POINTS, 32'd0);
        pending_items.push_back(tick(16'd0, 16'd0, 15'd0));
        drain();
        apb_write(REG_POINTS, 32'd31);
        pending_items.push_back(tick(16'd0, 16'hffff, 15'h4000));
        pending_items.push_back(tick(16'hffff, 16'd0, 15'd0));
        pending_items.push_back(tick(16'd0, 16'd0, 15'd1));
        add_walk(150);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            apb_write(REG_ANGLE_GAIN, (phase == 1) ? 32'd0 : 32'($urandom));
            apb_write(REG_DIST_GAIN, (phase == 2) ? 32'd0 : 32'($urandom));
            apb_write(REG_ANGLE_TOL, (phase == 3) ? 32'd4095 : 32'($urandom_range(0, 600)));
            apb_write(REG_DIST_TOL, (phase == 4) ? 32'd4095 : 32'($urandom_range(0, 1200)));
            apb_write(REG_POINTS, 32'($urandom_range(1, 16)));
            add_walk(300);
            drain();
        end
        $display("covered %0d result transactions over several gain, tolerance and route",
                 ticks_seen);
        $display("settings, with waypoint reloads mixed into pose ticks");
        if (errors == 0) begin
            $display("[waypoint_go_to_goal_controller] OK");
        end else begin
            $display("[waypoint_go_to_goal_controller] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[waypoint_go_to_goal_controller] ERROR");
        $finish;
    end
endmodule
